// ----- hdl/positional_pid_angle_wrap_assert.svh -----
// Assertion macros used by the port-level checker of the PID block.
`ifndef POSITIONAL_PID_ANGLE_WRAP_ASSERT_SVH
`define POSITIONAL_PID_ANGLE_WRAP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ppw_pkg.sv -----
// Package: register map, register widths and reset values of the PID block.
`default_nettype none

package ppw_pkg;

  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int GAIN_W   = 24;
  localparam int LIM_W    = 23;
  localparam int THR_W    = 24;
  localparam int HALF_W   = 22;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(76800);
  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(46080);

  typedef enum logic [2:0] {
    REG_KP_GAIN    = 3'd0,
    REG_KI_GAIN    = 3'd1,
    REG_KD_GAIN    = 3'd2,
    REG_INT_LIMIT  = 3'd3,
    REG_OUTPUT_MAX = 3'd4,
    REG_SEP_THRESH = 3'd5,
    REG_WRAP_EN    = 3'd6,
    REG_HALF_TURN  = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- hdl/positional_pid_angle_wrap.sv -----
// Positional PID controller with integral separation and angle wrap of the error.
// Each target/measurement beat is captured in an input register. The error, the wrap, the
// three gain products, the integral update and both clamps are then computed in one
// combinational pass into the output register. A new input beat can be accepted
// every cycle unless the output stalls: in_tready drops only while the input and
// output registers both hold beats and out_tready is low. The user must write registers
// through the APB port only while no beat is in flight; the block does not enforce it.
`default_nettype none

module positional_pid_angle_wrap
  import ppw_pkg::*;
#(
  parameter int DATA_WIDTH     = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // in_tdata: target_value, measured_value
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [((2*DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  // out_tdata: drive
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]       out_tdata,
  // out_tuser: saturated
  output logic                                  out_tuser,
  input  wire                                   cfg_psel,
  input  wire                                   cfg_penable,
  input  wire                                   cfg_pwrite,
  input  wire  [CFG_AW-1:0]                     cfg_paddr,
  input  wire  [CFG_DW-1:0]                     cfg_pwdata,
  output logic [CFG_DW-1:0]                     cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int EW     = DATA_WIDTH + 1;
  localparam int CW     = ((EW > HALF_W + 1) ? EW : HALF_W + 1) + 1;
  localparam int DEW    = EW + 1;
  localparam int TW     = ((EW > THR_W) ? EW : THR_W) + 1;
  localparam int GW     = GAIN_W + 1;
  localparam int PW     = GW + EW;
  localparam int PDW    = GW + DEW;
  localparam int PSW    = PW - GAIN_FRAC_BITS;
  localparam int DSW    = PDW - GAIN_FRAC_BITS;
  localparam int SW     = DSW + 1;
  localparam int LW     = (DATA_WIDTH > LIM_W + 1) ? DATA_WIDTH : LIM_W + 1;
  localparam int IW     = ((PSW > LW) ? PSW : LW) + 1;
  localparam int FW     = ((SW > LW) ? SW : LW) + 1;

  // config registers
  logic [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [LIM_W-1:0]  ilim_r, omax_r;
  logic [THR_W-1:0]  thr_r;
  logic              wrap_r;
  logic [HALF_W-1:0] half_r;
  logic              cfg_wr;
  cfg_reg_t          cfg_idx;

  // input register, one pass, output register
  logic                         s1_vld_r, out_vld_r;
  logic                         ld1, ld_o;
  logic signed [DATA_WIDTH-1:0] s1_tgt_r, s1_meas_r;
  logic signed [EW-1:0]         prev_err_r, err_nxt;
  logic signed [DEW-1:0]        derr_nxt;
  logic signed [CW-1:0]         diff_c, half_c;
  logic signed [PSW-1:0]        p_nxt, i_nxt;
  logic signed [DSW-1:0]        d_nxt;
  logic signed [PW-1:0]         prod_p, prod_i;
  logic signed [PDW-1:0]        prod_d;
  logic signed [TW-1:0]         err_t, thr_t;
  logic                         int_en;
  logic signed [SW-1:0]         pd_nxt;
  logic signed [LW-1:0]         int_sum_r, int_nxt;
  logic signed [IW-1:0]         isum, ilim_x;
  logic signed [FW-1:0]         dsum, omax_x;
  logic signed [DATA_WIDTH-1:0] drive_nxt;
  logic                         sat_nxt;
  logic [DATA_WIDTH-1:0]        out_drive_r;
  logic                         out_sat_r;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      ilim_r <= '0;
      omax_r <= '0;
      thr_r  <= THR_RESET;
      wrap_r <= 1'b0;
      half_r <= HALF_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KP_GAIN:    kp_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_KI_GAIN:    ki_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_KD_GAIN:    kd_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_INT_LIMIT:  ilim_r <= cfg_pwdata[LIM_W-1:0];
        REG_OUTPUT_MAX: omax_r <= cfg_pwdata[LIM_W-1:0];
        REG_SEP_THRESH: thr_r  <= cfg_pwdata[THR_W-1:0];
        REG_WRAP_EN:    wrap_r <= cfg_pwdata[0];
        REG_HALF_TURN:  half_r <= cfg_pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KP_GAIN:    cfg_prdata = CFG_DW'(kp_r);
      REG_KI_GAIN:    cfg_prdata = CFG_DW'(ki_r);
      REG_KD_GAIN:    cfg_prdata = CFG_DW'(kd_r);
      REG_INT_LIMIT:  cfg_prdata = CFG_DW'(ilim_r);
      REG_OUTPUT_MAX: cfg_prdata = CFG_DW'(omax_r);
      REG_SEP_THRESH: cfg_prdata = CFG_DW'(thr_r);
      REG_WRAP_EN:    cfg_prdata = CFG_DW'(wrap_r);
      REG_HALF_TURN:  cfg_prdata = CFG_DW'(half_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- beat flow ----------------
  assign ld_o      = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || ld_o;
  assign ld1       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      prev_err_r <= '0;
      int_sum_r  <= '0;
    end else begin
      if (ld1)             s1_vld_r  <= 1'b1;
      else if (ld_o)       s1_vld_r  <= 1'b0;
      if (ld_o)            out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
      if (ld_o) begin
        prev_err_r <= err_nxt;
        int_sum_r  <= int_nxt;
      end
    end
  end

  // ---------------- error, wrap, error change ----------------
  always_comb begin
    half_c = CW'($signed({1'b0, half_r}));
    diff_c = CW'(s1_tgt_r) - CW'(s1_meas_r);
    if (wrap_r && (diff_c > half_c)) begin
      diff_c = diff_c - (half_c <<< 1);
    end else if (wrap_r && (diff_c < -half_c)) begin
      diff_c = diff_c + (half_c <<< 1);
    end
    err_nxt  = diff_c[EW-1:0];
    derr_nxt = DEW'(err_nxt) - DEW'(prev_err_r);
  end

  // ---------------- gain products ----------------
  always_comb begin
    err_t  = TW'(err_nxt);
    thr_t  = TW'($signed({1'b0, thr_r}));
    int_en = (err_t <= thr_t) && (err_t >= -thr_t);
    prod_p = PW'($signed({1'b0, kp_r})) * PW'(err_nxt);
    prod_i = PW'($signed({1'b0, ki_r})) * PW'(err_nxt);
    prod_d = PDW'($signed({1'b0, kd_r})) * PDW'(derr_nxt);
    p_nxt  = prod_p[PW-1:GAIN_FRAC_BITS];
    i_nxt  = int_en ? prod_i[PW-1:GAIN_FRAC_BITS] : '0;
    d_nxt  = prod_d[PDW-1:GAIN_FRAC_BITS];
  end

  assign pd_nxt = SW'(p_nxt) + SW'(d_nxt);

  // ---------------- integral update ----------------
  always_comb begin
    ilim_x = IW'($signed({1'b0, ilim_r}));
    isum   = IW'(int_sum_r) + IW'(i_nxt);
    if (isum > ilim_x) begin
      isum = ilim_x;
    end else if (isum < -ilim_x) begin
      isum = -ilim_x;
    end
    int_nxt = isum[LW-1:0];
  end

  // ---------------- drive clamp ----------------
  always_comb begin
    omax_x  = FW'($signed({1'b0, omax_r}));
    dsum    = FW'(pd_nxt) + FW'(int_nxt);
    sat_nxt = 1'b0;
    if (dsum > omax_x) begin
      dsum    = omax_x;
      sat_nxt = 1'b1;
    end else if (dsum < -omax_x) begin
      dsum    = -omax_x;
      sat_nxt = 1'b1;
    end
    drive_nxt = dsum[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_tgt_r  <= in_tdata[DATA_WIDTH-1:0];
      s1_meas_r <= in_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    end
    if (ld_o) begin
      out_drive_r <= drive_nxt;
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TW'(out_drive_r);
  assign out_tuser  = out_sat_r;

endmodule

`default_nettype wire

// ----- hdl/ppw_checker.sv -----
// Port-level checker for the PID block and its bind to the top level.
`default_nettype none
`include "positional_pid_angle_wrap_assert.svh"

module ppw_checker
  import ppw_pkg::*;
#(
  parameter int DATA_WIDTH     = 24
) (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_tready,
  input wire                                  out_tvalid,
  input wire                                  out_tready,
  input wire [((DATA_WIDTH+7)/8)*8-1:0]       out_tdata,
  input wire                                  out_tuser,
  input wire                                  cfg_psel,
  input wire                                  cfg_penable,
  input wire                                  cfg_pwrite,
  input wire [CFG_AW-1:0]                     cfg_paddr,
  input wire [CFG_DW-1:0]                     cfg_pwdata,
  input wire                                  cfg_pready
);

  localparam int XW  = ((DATA_WIDTH > LIM_W) ? DATA_WIDTH : LIM_W) + 1;
  localparam int OTW = ((DATA_WIDTH + 7) / 8) * 8;

  logic [LIM_W-1:0]     omax_r;
  logic signed [XW-1:0] drv_x, omax_x;
  logic                 omax_fits;
  logic                 chk_en, drv_ok, drv_at_max, out_stall;
  logic [OTW:0]         out_beat;

  // shadow of the output clamp register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omax_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_reg_t'(cfg_paddr[CFG_AW-1:2]) == REG_OUTPUT_MAX)) begin
      omax_r <= cfg_pwdata[LIM_W-1:0];
    end
  end

  assign drv_x      = XW'($signed(out_tdata[DATA_WIDTH-1:0]));
  assign omax_x     = XW'($signed({1'b0, omax_r}));
  assign omax_fits  = (omax_x < (XW'(1) <<< (DATA_WIDTH - 1)));
  assign chk_en     = out_tvalid && omax_fits;
  assign drv_ok     = (drv_x <= omax_x) && (drv_x >= -omax_x);
  assign drv_at_max = (drv_x == omax_x) || (drv_x == -omax_x);
  assign out_stall  = out_tvalid && !out_tready;
  assign out_beat   = {out_tuser, out_tdata};

  `PPW_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid, "out beat dropped")
  `PPW_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_beat), "stalled out beat changed")
  `PPW_ASSERT_NOW(a_empty_ready, !out_tvalid, in_tready, "input stalled with empty output")
  `PPW_ASSERT_NOW(a_drive_range, chk_en, drv_ok, "drive beyond output clamp")
  `PPW_ASSERT_NOW(a_sat_value, chk_en && out_tuser, drv_at_max, "saturated drive not at clamp")

endmodule

bind positional_pid_angle_wrap ppw_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ppw_checker (.*);

`default_nettype wire

// ----- dv/positional_pid_angle_wrap_tb.sv -----
// Testbench for positional_pid_angle_wrap: predicts each drive beat and compares it.
`default_nettype none

module positional_pid_angle_wrap_tb;
  import ppw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DW           = 24;
  localparam int          FRAC         = 16;
  localparam longint      LIMIT_CYCLES = 400000;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 135;

  typedef struct packed {
    logic [DW-1:0] drive;
    logic          saturated;
  } pid_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;     // target_value [23:0], measured_value [47:24]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;    // drive [23:0]
  logic        out_tuser;    // saturated [0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic        cfg_pready;

  // controller copy: gains, clamps and state
  logic [23:0] kp_q, ki_q, kd_q, sep_q;
  logic [22:0] ilim_q, omax_q;
  logic        wrap_q;
  logic [21:0] half_q;
  longint      err_hist;
  longint      integ_acc;

  pid_result_t pending_drive[$];
  int unsigned fail_count;
  longint      cycle_count = 0;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  positional_pid_angle_wrap u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("positional_pid_angle_wrap_tb failed");
      $finish;
    end
  end

  function automatic longint clamp_sym(longint x, longint lim, output logic hit);
    hit = 1'b1;
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    hit = 1'b0;
    return x;
  endfunction

  // one controller step; updates the error history and integral
  function automatic pid_result_t compute_drive(logic signed [23:0] tgt,
                                                logic signed [23:0] meas);
    longint      err, h, p, d, mag, sum, drv;
    logic        hit;
    pid_result_t r;
    err = longint'(tgt) - longint'(meas);
    h   = longint'(half_q);
    if (wrap_q) begin
      if (err > h) err = err - 2 * h;
      else if (err < -h) err = err + 2 * h;
    end
    p   = (longint'(kp_q) * err) >>> FRAC;
    d   = (longint'(kd_q) * (err - err_hist)) >>> FRAC;
    mag = (err < 0) ? -err : err;
    sum = integ_acc;
    if (mag <= longint'(sep_q)) sum = sum + ((longint'(ki_q) * err) >>> FRAC);
    integ_acc = clamp_sym(sum, longint'(ilim_q), hit);
    drv = clamp_sym(p + d + integ_acc, longint'(omax_q), hit);
    err_hist = err;
    r.drive = drv[DW-1:0];
    r.saturated = hit;
    return r;
  endfunction

  // write a register with noise above its width, then read it back
  task automatic cfg_write(cfg_reg_t idx, logic [31:0] value);
    int unsigned w;
    logic [31:0] masked;
    logic [31:0] noise;
    case (idx)
      REG_KP_GAIN, REG_KI_GAIN, REG_KD_GAIN, REG_SEP_THRESH: w = 24;
      REG_INT_LIMIT, REG_OUTPUT_MAX: w = 23;
      REG_WRAP_EN: w = 1;
      default: w = 22;
    endcase
    masked = value & ((32'd1 << w) - 32'd1);
    noise = $urandom;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= masked | (noise << w);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_KP_GAIN:    kp_q   = masked[23:0];
      REG_KI_GAIN:    ki_q   = masked[23:0];
      REG_KD_GAIN:    kd_q   = masked[23:0];
      REG_INT_LIMIT:  ilim_q = masked[22:0];
      REG_OUTPUT_MAX: omax_q = masked[22:0];
      REG_SEP_THRESH: sep_q  = masked[23:0];
      REG_WRAP_EN:    wrap_q = masked[0];
      default:        half_q = masked[21:0];
    endcase
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== masked) begin
      $error("register %s: expected %0h, got %0h", idx.name(), masked, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic cfg_read_check(cfg_reg_t idx, logic [31:0] want);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("register %s: expected %0h, got %0h", idx.name(), want, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                               logic [31:0] ilim, logic [31:0] omax, logic [31:0] sep,
                               logic [31:0] wrap, logic [31:0] half);
    cfg_write(REG_KP_GAIN, kp);
    cfg_write(REG_KI_GAIN, ki);
    cfg_write(REG_KD_GAIN, kd);
    cfg_write(REG_INT_LIMIT, ilim);
    cfg_write(REG_OUTPUT_MAX, omax);
    cfg_write(REG_SEP_THRESH, sep);
    cfg_write(REG_WRAP_EN, wrap);
    cfg_write(REG_HALF_TURN, half);
  endtask

  task automatic send_sample(logic signed [23:0] tgt, logic signed [23:0] meas);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, tgt};
    do @(posedge clk); while (!in_tready);
    pending_drive.push_back(compute_drive(tgt, meas));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 82; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 82; end
      default: begin send_gap_pct = 28; stall_pct = 28; end
    endcase
  endtask

  // errors near the threshold, the half turn and the full turn, small errors, plus full-range noise
  task automatic send_random_sample();
    logic signed [23:0] meas, tgt;
    longint             delta;
    meas = 24'($urandom);
    if ($urandom_range(99) < 30) begin
      tgt = 24'($urandom);
    end else begin
      case ($urandom_range(4))
        0: delta = longint'(sep_q) + int'($urandom_range(4)) - 2;
        1: delta = longint'(half_q) + int'($urandom_range(4)) - 2;
        2: delta = 2 * longint'(half_q) + int'($urandom_range(8)) - 4;
        3: delta = int'($urandom_range(8191)) - 4096;
        default: delta = longint'($urandom_range(255));
      endcase
      if ($urandom_range(1)) delta = -delta;
      tgt = 24'(longint'(meas) + delta);
    end
    send_sample(tgt, meas);
  endtask

  task automatic program_random(int unsigned style);
    case (style)
      0: program_gains(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h007F_FFFF,
                       32'h007F_FFFF, 32'h00FF_FFFF, 1, 32'h003F_FFFF);
      1: program_gains($urandom_range(1 << 18), $urandom_range(1 << 15),
                       $urandom_range(1 << 18), 0, 0, $urandom_range(1 << 20),
                       $urandom_range(1), $urandom_range(1 << 21));
      2: program_gains($urandom_range(1 << 18), $urandom_range(1 << 15),
                       $urandom_range(1 << 18), $urandom_range(1 << 20),
                       $urandom_range(1 << 22), $urandom_range(1 << 20), 1, 0);
      default: program_gains($urandom_range(1 << 18), $urandom_range(1 << 15),
                             $urandom_range(1 << 18), $urandom_range(1 << 21),
                             $urandom_range(1 << 23), $urandom_range(1 << 21),
                             $urandom_range(1), $urandom_range(1 << 21));
    endcase
  endtask

  task automatic test_reset_values();
    set_idling(0);
    cfg_read_check(REG_KP_GAIN, 0);
    cfg_read_check(REG_KI_GAIN, 0);
    cfg_read_check(REG_KD_GAIN, 0);
    cfg_read_check(REG_INT_LIMIT, 0);
    cfg_read_check(REG_OUTPUT_MAX, 0);
    cfg_read_check(REG_SEP_THRESH, 32'(THR_RESET));
    cfg_read_check(REG_WRAP_EN, 0);
    cfg_read_check(REG_HALF_TURN, 32'(HALF_RESET));
    send_sample(24'sd1000, 24'sd0);
    send_sample(24'h7FFFFF, 24'h800000);
    send_sample(24'h800000, 24'h7FFFFF);
    wait_drain();
  endtask

  task automatic test_directed();
    set_idling(0);
    program_gains(1 << 16, 1 << 14, 1 << 15, 5000, 200000, 1000, 1, 46080);
    send_sample(24'sd0, 24'sd0);
    send_sample(24'h7FFFFF, 24'h800000);
    send_sample(24'h800000, 24'h7FFFFF);
    send_sample(24'h7FFFFF, 24'h7FFFFF);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'sd46080, 24'sd0);
    send_sample(24'sd46081, 24'sd0);
    send_sample(24'sd0, 24'sd46080);
    send_sample(24'sd0, 24'sd46081);
    send_sample(24'sd1000, 24'sd0);
    send_sample(24'sd1001, 24'sd0);
    send_sample(24'sd0, 24'sd1000);
    send_sample(24'sd0, 24'sd1001);
    wait_drain();
    // angle mode with no half turn
    cfg_write(REG_HALF_TURN, 0);
    send_sample(24'sd500, 24'sd0);
    send_sample(24'sd0, 24'sd70000);
    wait_drain();
    // both clamps at zero
    cfg_write(REG_INT_LIMIT, 0);
    cfg_write(REG_OUTPUT_MAX, 0);
    send_sample(24'sd3000, 24'sd0);
    send_sample(24'sd3000, 24'sd3000);
    send_sample(-24'sd5, 24'sd0);
    wait_drain();
  endtask

  task automatic test_random_phases();
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      set_idling(ph % 4);
      program_random(ph % 5);
      repeat (PHASE_ITEMS) send_random_sample();
      wait_drain();
    end
  endtask

  task automatic test_backpressure();
    set_idling(0);
    program_random(3);
    hold_left = 300;
    repeat (60) send_random_sample();
    wait_drain();
  endtask

  // receiver side: random stalls plus one long hold-off set by the backpressure test
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    pid_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drive.size() == 0) begin
        $error("unexpected drive beat: drive %0h saturated %0b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_drive.pop_front();
        if (out_tdata !== want.drive) begin
          $error("drive: expected %0h, got %0h", want.drive, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    fail_count  = 0;
    hold_left   = 0;
    send_gap_pct = 0;
    stall_pct   = 0;
    kp_q = '0;
    ki_q = '0;
    kd_q = '0;
    ilim_q = '0;
    omax_q = '0;
    sep_q  = THR_RESET;
    wrap_q = 1'b0;
    half_q = HALF_RESET;
    err_hist  = 0;
    integ_acc = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed();
    test_backpressure();
    test_random_phases();

    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_drive.size() == 0) begin
      $display("positional_pid_angle_wrap_tb passed");
    end else begin
      $display("positional_pid_angle_wrap_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
